### sv/sida_pkg.sv
// shared types, constants and the double dabble step for the decimal ascii converter
package sida_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGITS = 10;
    localparam int BCD_W = 4 * DIGITS;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES = VALUE_W / STEPS_PER_STAGE;
    localparam int IDX_W = $clog2(DIGITS);
    localparam int CHAR_W = 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
    } dd_t;

    // one shift-and-add-3 step
    function automatic dd_t dabble_step(dd_t d);
        dd_t r;
        r = d;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (r.bcd[4*i +: 4] >= 4'd5)
            begin
                r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
            end
        end
        r.bcd = {r.bcd[BCD_W-2:0], r.bin[VALUE_W-1]};
        r.bin = {r.bin[VALUE_W-2:0], 1'b0};
        return r;
    endfunction

endpackage

### sv/sida_dabble_stage.sv
// one pipeline stage of the binary to bcd conversion
module sida_dabble_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sida_pkg::dd_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sida_pkg::dd_t out_data
);
    import sida_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;

    always_comb
    begin
        data_next = in_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            data_next = dabble_step(data_next);
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

### sv/sida_serializer.sv
// emits the sign and the significant bcd digits one character per transfer
module sida_serializer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sida_pkg::dd_t               in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sida_pkg::CHAR_W-1:0] out_char,
    output logic                        out_last
);
    import sida_pkg::*;

    logic             busy_reg;
    logic             neg_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] top_idx;
    logic             out_xfer;
    logic             load;

    // highest nonzero digit, zero gives a single digit
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (in_data.bcd[4*i +: 4] != 4'd0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign out_valid = busy_reg;
    assign out_char = neg_reg ? CHAR_MINUS : (CHAR_ZERO + {4'd0, bcd_reg[4*idx_reg +: 4]});
    assign out_last = !neg_reg && (idx_reg == '0);
    assign out_xfer = out_valid && out_ready;
    assign in_ready = !busy_reg || (out_xfer && out_last);
    assign load = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            neg_reg <= 1'b0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            neg_reg <= in_data.neg;
            idx_reg <= top_idx;
        end
        else if (out_xfer)
        begin
            if (neg_reg)
            begin
                neg_reg <= 1'b0;
            end
            else if (idx_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_data.bcd;
        end
    end

endmodule

### sv/signed_int_to_decimal_ascii_core.sv
// Converts a signed 32-bit integer to decimal ascii text, one character per output transfer,
// most significant first: a minus sign for negative values, then the digits of the magnitude
// without leading zeros (zero gives a single '0'); tlast marks the last character of each
// number. An input register takes the magnitude, eight stages of four shift-and-add-3 steps
// each build the bcd digits, and a serializer sends the characters. Each number gives one to
// eleven characters, one per output transfer, so the serializer limits the sustained throughput;
// it takes the next number as the last character of the current one is transferred.
// Up to ten numbers wait in the pipeline while the output is busy or stalled.
module signed_int_to_decimal_ascii_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // value[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // character[7:0]
    output logic        m_tlast
);
    import sida_pkg::*;

    logic valid_reg;
    dd_t  data_reg;
    dd_t  data_next;

    logic stg_valid [NUM_STAGES+1];
    logic stg_ready [NUM_STAGES+1];
    dd_t  stg_data  [NUM_STAGES+1];

    always_comb
    begin
        data_next.neg = s_tdata[VALUE_W-1];
        data_next.bin = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_tdata) : s_tdata;
        data_next.bcd = '0;
    end

    assign s_tready = !valid_reg || stg_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= data_next;
        end
    end

    assign stg_valid[0] = valid_reg;
    assign stg_data[0] = data_reg;

    for (genvar g = 0; g < NUM_STAGES; g++)
    begin : g_stage
        sida_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_data   (stg_data[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_data  (stg_data[g+1])
        );
    end

    sida_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (stg_valid[NUM_STAGES]),
        .in_ready  (stg_ready[NUM_STAGES]),
        .in_data   (stg_data[NUM_STAGES]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

### test/signed_int_to_decimal_ascii_core_tb.sv
// testbench for the signed integer to decimal ascii converter: corner and random values checked per character
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_core_tb;

    import sida_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 150;
    localparam logic [VALUE_W-1:0] DECIMAL_BASE = 32'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } ascii_char_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [CHAR_W-1:0]  m_tdata;
    logic               m_tlast;

    logic [VALUE_W-1:0] pending_values[$];
    ascii_char_t        expected_text[$];

    int send_idle_pct = 17;
    int recv_idle_pct = 61;
    int mismatches = 0;
    int numbers_sent = 0;
    int negatives_sent = 0;
    int chars_checked = 0;
    int stall_cycles = 0;

    signed_int_to_decimal_ascii_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // value[31:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // character[7:0]
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // appends the decimal text of one number to the expected characters
    function automatic void predict_text(logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits[DIGITS];
        ascii_char_t        c;
        int                 ndig;
        magnitude = value[VALUE_W-1] ? -value : value;
        ndig = 1;
        for (int k = 0; k < DIGITS; k++)
        begin
            digits[k] = 4'(magnitude % DECIMAL_BASE);
            magnitude = magnitude / DECIMAL_BASE;
            if (digits[k] != 4'd0)
            begin
                ndig = k + 1;
            end
        end
        if (value[VALUE_W-1])
        begin
            c.character = CHAR_MINUS;
            c.last_char = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            c.character = CHAR_ZERO + {4'd0, digits[k]};
            c.last_char = (k == 0);
            expected_text.push_back(c);
        end
    endfunction

    // source side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_text(s_tdata);
                numbers_sent++;
                if (s_tdata[VALUE_W-1])
                begin
                    negatives_sent++;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_values.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                    s_tdata <= $urandom;
                end
            end
        end
    end

    // sink side and character check
    always @(posedge clk or negedge rst_n)
    begin
        ascii_char_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                chars_checked++;
                if (expected_text.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transfer, actual character %0d last %b",
                             $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (m_tdata !== want.character)
                    begin
                        mismatches++;
                        $display("%0t: character mismatch, expected %0d actual %0d",
                                 $time, want.character, m_tdata);
                    end
                    if (m_tlast !== want.last_char)
                    begin
                        mismatches++;
                        $display("%0t: tlast mismatch, expected %b actual %b",
                                 $time, want.last_char, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout at %0t, %0d characters outstanding",
                         $time, expected_text.size());
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial
    begin
        logic [VALUE_W-1:0] lo;
        logic [VALUE_W-1:0] hi;
        logic [VALUE_W-1:0] mag;
        int                 ndig;

        // corner values: zero, single digits, digit-count boundaries, both extremes
        pending_values.push_back(32'd0);
        pending_values.push_back(32'd1);
        pending_values.push_back(-32'sd1);
        pending_values.push_back(32'd9);
        pending_values.push_back(32'd10);
        pending_values.push_back(-32'sd10);
        pending_values.push_back(32'd99);
        pending_values.push_back(32'd100);
        pending_values.push_back(-32'sd5);
        pending_values.push_back(32'h7FFF_FFFF);
        pending_values.push_back(32'h8000_0000);
        pending_values.push_back(32'h8000_0001);
        pending_values.push_back(32'd999999999);
        pending_values.push_back(32'd1000000000);
        pending_values.push_back(-32'sd1000000000);
        pending_values.push_back(32'd1234567890);
        pending_values.push_back(-32'sd987654321);
        pending_values.push_back(32'h5555_5555);
        pending_values.push_back(32'hAAAA_AAAA);
        pending_values.push_back(32'd1000);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            if (phase == 1)
            begin
                send_idle_pct <= 61;
                recv_idle_pct <= 17;
            end
            else if (phase == 2)
            begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(3) == 0)
                begin
                    pending_values.push_back($urandom);
                end
                else
                begin
                    // even spread over digit counts, random sign
                    ndig = $urandom_range(DIGITS, 1);
                    lo = (ndig == 1) ? 32'd0 : 32'd1;
                    for (int k = 1; k < ndig; k++)
                    begin
                        lo = lo * DECIMAL_BASE;
                    end
                    hi = (ndig == DIGITS) ? 32'h7FFF_FFFF
                         : ((ndig == 1) ? 32'd9 : lo * DECIMAL_BASE - 32'd1);
                    mag = $urandom_range(hi, lo);
                    pending_values.push_back($urandom_range(1) ? -mag : mag);
                end
            end
            while (pending_values.size() != 0)
            begin
                @(posedge clk);
            end
        end

        while (s_tvalid || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("converted %0d numbers (%0d negative) into %0d checked characters",
                 numbers_sent, negatives_sent, chars_checked);
        $display("idle mixes: source-light/sink-heavy, reversed, and back-to-back");
        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
